[rtl/assert_macros.svh]
// Assertion helpers shared by the mesher modules.
// Every user is expected to have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define HGM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define HGM_NEVER(lbl, cond, msg) \
  `HGM_ASSERT(lbl, !(cond), msg)

`endif

[rtl/hgm_pkg.sv]
`timescale 1ns / 1ps

package hgm_pkg;

  // Grid limits and the height store.
  localparam int MAX_SIDE    = 129;
  localparam int MAX_LOD     = 7;
  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // Shared integer divider widths.
  localparam int DIV_NW = 24;
  localparam int DIV_DW = 8;

  // Magnitude width of a normal sum component.
  localparam int MAG_W = 26;

  // Input mode codes.
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_VERT = 2'd1;
  localparam logic [1:0] MODE_TRI  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SIDE    = 2'd0;
  localparam logic [1:0] CFG_LOD     = 2'd1;
  localparam logic [1:0] CFG_SPACING = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_VERT,
    OP_TRI
  } op_t;

  // Geometry derived from the configuration registers.
  typedef struct packed {
    logic [7:0]  side;
    logic [7:0]  step;
    logic [7:0]  grid;
    logic [7:0]  vps;
    logic [15:0] spacing;
  } geom_t;

  // One classified request waiting for the back end.
  typedef struct packed {
    op_t         op;
    logic        err;
    logic [14:0] item;
    logic [15:0] height;
  } job_t;

  typedef struct packed {
    logic [14:0]        corner_c;
    logic [14:0]        corner_b;
    logic [14:0]        corner_a;
    logic signed [15:0] norm_z;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_x;
    logic [16:0]        tex_v;
    logic [16:0]        tex_u;
    logic [22:0]        pos_z;
    logic signed [15:0] pos_y;
    logic [22:0]        pos_x;
    logic               status;
  } result_t;

endpackage

[rtl/heightfield_grid_mesher_unit.sv]
`timescale 1ns / 1ps

// Channel   Ports                      Contents
// input     in_tvalid/tready/tdata     mode, height, item_index
// result    out_tvalid/tready/tdata    status, position, texture, normal, corners
// config    cfg_we/index/wdata         side_length, lod_level, grid_spacing
//
// A load is written to the height store as it leaves the queue; a triangle request runs one
// 24-step divide. A vertex request runs three 24-step divides and nine height reads, and
// unless the spacing is zero also up to 30 normalize steps, a 32-step square root and three
// 17-step divides; the 24-step divides share one divider unit, the rest run in the sequencer.
// Reset is synchronous, active low; the height store holds no reset value.
// A two-entry queue lets input transfers continue while the back end works
// or while a finished result waits in the output register.

module heightfield_grid_mesher_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] mode, [17:2] height, [32:18] item_index, [39:33] zero
  input  logic [39:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] status, [23:1] pos_x, [39:24] pos_y, [62:40] pos_z, [79:63] tex_u,
  // [96:80] tex_v, [112:97] norm_x, [128:113] norm_y, [144:129] norm_z,
  // [159:145] corner_a, [174:160] corner_b, [189:175] corner_c, [191:190] zero
  output logic [191:0] out_tdata
);
  import hgm_pkg::*;

  logic    full;
  logic    empty;
  logic    push;
  logic    pop;
  job_t    job_in;
  job_t    job_head;
  geom_t   geom;
  result_t res;

  hgm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid_i (in_tvalid),
    .in_ready_o (in_tready),
    .mode_i     (in_tdata[1:0]),
    .height_i   (in_tdata[17:2]),
    .item_i     (in_tdata[32:18]),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_in),
    .geom_o     (geom)
  );

  hgm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .head_o  (job_head),
    .full_o  (full),
    .empty_o (empty)
  );

  hgm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .geom_i      (geom),
    .job_i       (job_head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_o       (res)
  );

  // Result packing, status field in the lowest bits.
  assign out_tdata = {2'b00, res};

endmodule

[rtl/hgm_front.sv]
`timescale 1ns / 1ps

module hgm_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_wdata,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     mode_i,
  input  logic [15:0]    height_i,
  input  logic [14:0]    item_i,
  input  logic           full_i,
  output logic           push_o,
  output hgm_pkg::job_t  job_o,
  output hgm_pkg::geom_t geom_o
);
  import hgm_pkg::*;

  logic [7:0]  side_r;
  logic [2:0]  lod_r;
  logic [15:0] spacing_r;

  logic [2:0]  lod_eff;
  logic [7:0]  pow;
  logic [7:0]  side_m1;
  logic [7:0]  step;
  logic [7:0]  grid;
  logic [7:0]  vps;
  logic        empty;
  logic [15:0] vcount;
  logic [16:0] tcount;
  logic        keep;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r    <= 8'(MAX_SIDE);
      lod_r     <= 3'd0;
      spacing_r <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIDE:    side_r    <= cfg_wdata[7:0];
        CFG_LOD:     lod_r     <= cfg_wdata[2:0];
        CFG_SPACING: spacing_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stride, cell count and vertices per side for the current setup.
  always_comb begin
    lod_eff = (lod_r > 3'(MAX_LOD)) ? 3'(MAX_LOD) : lod_r;
    pow     = 8'd1 << lod_eff;
    side_m1 = side_r - 8'd1;
    if (pow >= side_r) begin
      step = side_m1;
      grid = 8'd1;
    end else begin
      step = pow;
      grid = side_m1 >> lod_eff;
    end
    vps    = grid + 8'd1;
    empty  = (side_r < 8'd2) || (side_r > 8'(MAX_SIDE));
    vcount = vps * vps;
    tcount = {1'b0, 16'(grid) * 16'(grid)} << 1;
  end

  assign geom_o = '{side: side_r, step: step, grid: grid, vps: vps, spacing: spacing_r};

  // Classify the request, flag range errors on vertex and triangle requests, drop bad loads and modes.
  always_comb begin
    job_o.item   = item_i;
    job_o.height = height_i;
    job_o.op     = OP_LOAD;
    job_o.err    = 1'b0;
    keep         = 1'b0;
    unique case (mode_i)
      MODE_LOAD: begin
        keep = (item_i < 15'(STORE_DEPTH));
      end
      MODE_VERT: begin
        keep      = 1'b1;
        job_o.op  = OP_VERT;
        job_o.err = empty || ({1'b0, item_i} >= vcount);
      end
      MODE_TRI: begin
        keep      = 1'b1;
        job_o.op  = OP_TRI;
        job_o.err = empty || ({2'b00, item_i} >= tcount);
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && keep;

endmodule

[rtl/hgm_queue.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hgm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  hgm_pkg::job_t job_i,
  input  logic          pop_i,
  output hgm_pkg::job_t head_o,
  output logic          full_o,
  output logic          empty_o
);
  import hgm_pkg::*;

  job_t            slot_r [QDEPTH];
  logic [QAW-1:0]  wr_r;
  logic [QAW-1:0]  rd_r;
  logic [QAW:0]    count_r;

  assign full_o  = (count_r == (QAW+1)'(QDEPTH));
  assign empty_o = (count_r == '0);
  assign head_o  = slot_r[rd_r];

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push_i) begin
      slot_r[wr_r] <= job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push_i) begin
        wr_r <= (wr_r == QAW'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop_i) begin
        rd_r <= (rd_r == QAW'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + 1'b1;
      end else if (pop_i && !push_i) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `HGM_ASSERT(a_q_count, count_r <= (QAW+1)'(QDEPTH), "queue count beyond depth")
  `HGM_NEVER(a_q_push_full, push_i && full_o, "push into a full queue")
  `HGM_NEVER(a_q_pop_empty, pop_i && empty_o, "pop from an empty queue")

endmodule

[rtl/hgm_div.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hgm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic [hgm_pkg::DIV_NW-1:0] num_i,
  input  logic [hgm_pkg::DIV_DW-1:0] den_i,
  output logic                       done_o,
  output logic [hgm_pkg::DIV_NW-1:0] quot_o,
  output logic [hgm_pkg::DIV_DW-1:0] rem_o
);
  import hgm_pkg::*;

  localparam int CW = $clog2(DIV_NW);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW:0]   trial;
  logic              ge;

  // One restoring step per cycle; quotient bits shift in behind the dividend.
  assign trial = {rem_r, num_r[DIV_NW-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start_i && (cnt_r == CW'(DIV_NW - 1));
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= num_i;
        den_r  <= den_i;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
        num_r <= {num_r[DIV_NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_r;
  assign quot_o = num_r;
  assign rem_o  = rem_r;

  `HGM_NEVER(a_div_restart, start_i && busy_r, "divider started while busy")

endmodule

[rtl/hgm_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hgm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  hgm_pkg::geom_t   geom_i,
  input  hgm_pkg::job_t    job_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hgm_pkg::result_t out_o
);
  import hgm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TDIV, ST_TCALC, ST_VDIV, ST_VPOS1, ST_VPOS2, ST_TU, ST_TV,
    ST_FADDR, ST_FDATA, ST_ACC, ST_SQ, ST_NORM, ST_SQRT, ST_NSET, ST_NDIV, ST_EMIT
  } state_t;

  state_t state_r;

  // Height store.
  logic [15:0]       mem [STORE_DEPTH];
  logic [15:0]       rd_data_r;
  logic [ADDR_W-1:0] rd_addr;

  // Shared divider.
  logic              div_go_r;
  logic [DIV_NW-1:0] div_num_r;
  logic [DIV_DW-1:0] div_den_r;
  logic              div_done;
  logic [DIV_NW-1:0] div_quot;
  logic [DIV_DW-1:0] div_rem;

  // Request and geometry working registers.
  logic               which_r;
  logic [7:0]         ix_r;
  logic [7:0]         iz_r;
  logic [7:0]         sx_r;
  logic [7:0]         sz_r;
  logic [23:0]        d_r;
  logic [1:0]         dx_r;
  logic [1:0]         dz_r;
  logic signed [15:0] h_r [3][3];
  result_t            res_r;
  result_t            out_r;
  logic               out_valid_r;

  // Normal arithmetic registers.
  logic [MAG_W-1:0]   mag_r [3];
  logic               neg0_r;
  logic               neg2_r;
  logic [1:0]         comp_r;
  logic [4:0]         cnt_r;
  logic [4:0]         s_r;
  logic [63:0]        n_r;
  logic [63:0]        r_r;
  logic [63:0]        bit_r;
  logic [31:0]        rem_r;
  logic [16:0]        nlo_r;
  logic [16:0]        q_r;

  hgm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_go_r),
    .num_i   (div_num_r),
    .den_i   (div_den_r),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // Neighborhood tap address; taps off the grid read entry zero and are masked.
  logic        z_ok;
  logic        x_ok;
  logic        tap_ok;
  logic [8:0]  rz;
  logic [8:0]  rx;
  logic [17:0] addr_full;

  always_comb begin
    z_ok = (dz_r == 2'd0) ? (iz_r != 8'd0) : (dz_r == 2'd2) ? (iz_r < geom_i.grid) : 1'b1;
    x_ok = (dx_r == 2'd0) ? (ix_r != 8'd0) : (dx_r == 2'd2) ? (ix_r < geom_i.grid) : 1'b1;
    tap_ok = z_ok && x_ok;
    rz = (dz_r == 2'd0) ? ({1'b0, sz_r} - {1'b0, geom_i.step}) :
         (dz_r == 2'd2) ? ({1'b0, sz_r} + {1'b0, geom_i.step}) : {1'b0, sz_r};
    rx = (dx_r == 2'd0) ? ({1'b0, sx_r} - {1'b0, geom_i.step}) :
         (dx_r == 2'd2) ? ({1'b0, sx_r} + {1'b0, geom_i.step}) : {1'b0, sx_r};
    addr_full = 18'(rz * geom_i.side) + {9'd0, rx};
    rd_addr   = tap_ok ? addr_full[ADDR_W-1:0] : '0;
  end

  // Face sums over the triangles that touch the vertex.
  logic signed [19:0] hh [3][3];
  logic               own_c;
  logic               lft_c;
  logic               up_c;
  logic               dg_c;
  logic signed [19:0] a0;
  logic signed [19:0] a2;
  logic [2:0]         nfaces;
  logic [26:0]        a1;

  always_comb begin
    for (int z = 0; z < 3; z++) begin
      for (int x = 0; x < 3; x++) begin
        hh[z][x] = {{4{h_r[z][x][15]}}, h_r[z][x]};
      end
    end
    own_c = (ix_r < geom_i.grid) && (iz_r < geom_i.grid);
    lft_c = (ix_r != 8'd0) && (iz_r < geom_i.grid);
    up_c  = (ix_r < geom_i.grid) && (iz_r != 8'd0);
    dg_c  = (ix_r != 8'd0) && (iz_r != 8'd0);
    a0 = '0;
    a2 = '0;
    if (own_c) begin
      a0 = a0 + (hh[1][1] - hh[1][2]);
      a2 = a2 + (hh[1][1] - hh[2][1]);
    end
    if (lft_c) begin
      a0 = a0 + (hh[1][0] - hh[1][1]) + (hh[2][0] - hh[2][1]);
      a2 = a2 + (hh[1][0] - hh[2][0]) + (hh[1][1] - hh[2][1]);
    end
    if (up_c) begin
      a0 = a0 + (hh[0][1] - hh[0][2]) + (hh[1][1] - hh[1][2]);
      a2 = a2 + (hh[0][1] - hh[1][1]) + (hh[0][2] - hh[1][2]);
    end
    if (dg_c) begin
      a0 = a0 + (hh[1][0] - hh[1][1]);
      a2 = a2 + (hh[0][1] - hh[1][1]);
    end
    nfaces = {2'b00, own_c} + {1'b0, lft_c, 1'b0} + {1'b0, up_c, 1'b0} + {2'b00, dg_c};
    a1     = 27'(nfaces * d_r);
  end

  // Squaring, root step and normal division step.
  logic [MAG_W-1:0] mag_sel;
  logic [51:0]      sq;
  logic [63:0]      root_t;
  logic [5:0]       sh;
  logic [71:0]      nfull;
  logic [32:0]      trial;
  logic             ge;
  logic [16:0]      q_fin;
  logic [14:0]      q_sat;
  logic             neg_sel;
  logic [15:0]      norm_v;

  always_comb begin
    mag_sel = mag_r[comp_r];
    sq      = mag_sel * mag_sel;
    root_t  = r_r + bit_r;
    sh      = {1'b0, s_r} + 6'd14;
    nfull   = (72'(mag_sel) << sh) + 72'(r_r[31:1]);
    trial   = {rem_r, nlo_r[16]};
    ge      = (trial >= {1'b0, r_r[31:0]});
    q_fin   = {q_r[15:0], ge};
    q_sat   = (q_fin > 17'd16384) ? 15'd16384 : q_fin[14:0];
    neg_sel = (comp_r == 2'd0) ? neg0_r : (comp_r == 2'd2) ? neg2_r : 1'b0;
    norm_v  = neg_sel ? (16'd0 - {1'b0, q_sat}) : {1'b0, q_sat};
  end

  assign pop_o = (state_r == ST_IDLE) && !empty_i;

  // Height store write on loads and registered read.
  always_ff @(posedge clk) begin
    if (pop_o && (job_i.op == OP_LOAD)) begin
      mem[job_i.item[ADDR_W-1:0]] <= job_i.height;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      cnt_r       <= '0;
      comp_r      <= '0;
      dx_r        <= '0;
      dz_r        <= '0;
    end else begin
      // Divider starts: a new request, the two texture divides.
      div_go_r <= ((state_r == ST_IDLE) && !empty_i && (job_i.op != OP_LOAD) &&
                   !job_i.err) ||
                  (state_r == ST_VPOS2) || ((state_r == ST_TU) && div_done);
      if (out_valid_r && out_ready_i && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!empty_i) begin
            res_r   <= result_t'({{($bits(result_t) - 1){1'b0}}, job_i.err});
            which_r <= job_i.item[0];
            if (job_i.op != OP_LOAD) begin
              if (job_i.err) begin
                state_r <= ST_EMIT;
              end else begin
                if (job_i.op == OP_VERT) begin
                  div_num_r <= DIV_NW'(job_i.item);
                  div_den_r <= geom_i.vps;
                  state_r   <= ST_VDIV;
                end else begin
                  div_num_r <= DIV_NW'(job_i.item[14:1]);
                  div_den_r <= geom_i.grid;
                  state_r   <= ST_TDIV;
                end
              end
            end
          end
        end
        ST_TDIV: begin
          if (div_done) begin
            ix_r    <= div_rem;
            iz_r    <= div_quot[7:0];
            state_r <= ST_TCALC;
          end
        end
        ST_TCALC: begin
          logic [15:0] tl;
          tl = 16'(iz_r * geom_i.vps) + {8'd0, ix_r};
          res_r.corner_b <= 15'(tl + {8'd0, geom_i.vps});
          if (which_r) begin
            res_r.corner_a <= 15'(tl + 16'd1);
            res_r.corner_c <= 15'(tl + {8'd0, geom_i.vps} + 16'd1);
          end else begin
            res_r.corner_a <= tl[14:0];
            res_r.corner_c <= 15'(tl + 16'd1);
          end
          state_r <= ST_EMIT;
        end
        ST_VDIV: begin
          if (div_done) begin
            ix_r    <= div_rem;
            iz_r    <= div_quot[7:0];
            state_r <= ST_VPOS1;
          end
        end
        ST_VPOS1: begin
          sx_r    <= 8'(ix_r * geom_i.step);
          sz_r    <= 8'(iz_r * geom_i.step);
          d_r     <= geom_i.step * geom_i.spacing;
          state_r <= ST_VPOS2;
        end
        ST_VPOS2: begin
          res_r.pos_x <= 23'(sx_r * geom_i.spacing);
          res_r.pos_z <= 23'(sz_r * geom_i.spacing);
          div_num_r   <= {ix_r, 16'd0} + DIV_NW'(geom_i.grid >> 1);
          div_den_r   <= geom_i.grid;
          state_r     <= ST_TU;
        end
        ST_TU: begin
          if (div_done) begin
            res_r.tex_u <= div_quot[16:0];
            div_num_r   <= {iz_r, 16'd0} + DIV_NW'(geom_i.grid >> 1);
            state_r     <= ST_TV;
          end
        end
        ST_TV: begin
          if (div_done) begin
            res_r.tex_v <= div_quot[16:0];
            dx_r        <= '0;
            dz_r        <= '0;
            state_r     <= ST_FADDR;
          end
        end
        ST_FADDR: begin
          state_r <= ST_FDATA;
        end
        ST_FDATA: begin
          h_r[dz_r][dx_r] <= tap_ok ? rd_data_r : 16'd0;
          if (dx_r == 2'd2) begin
            dx_r <= '0;
            dz_r <= dz_r + 2'd1;
            state_r <= (dz_r == 2'd2) ? ST_ACC : ST_FADDR;
          end else begin
            dx_r    <= dx_r + 2'd1;
            state_r <= ST_FADDR;
          end
        end
        ST_ACC: begin
          res_r.pos_y <= h_r[1][1];
          mag_r[0]    <= MAG_W'(a0[19] ? -a0 : a0);
          mag_r[1]    <= a1[MAG_W-1:0];
          mag_r[2]    <= MAG_W'(a2[19] ? -a2 : a2);
          neg0_r      <= a0[19];
          neg2_r      <= a2[19];
          n_r         <= '0;
          s_r         <= '0;
          comp_r      <= '0;
          state_r     <= (d_r == 24'd0) ? ST_EMIT : ST_SQ;
        end
        ST_SQ: begin
          n_r <= n_r + 64'(sq);
          if (comp_r == 2'd2) begin
            comp_r  <= '0;
            state_r <= ST_NORM;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end
        ST_NORM: begin
          if (n_r == 64'd0) begin
            state_r <= ST_EMIT;
          end else if (n_r[63:60] == 4'd0) begin
            n_r <= n_r << 2;
            s_r <= s_r + 5'd1;
          end else begin
            r_r     <= '0;
            bit_r   <= {2'b01, 62'd0};
            cnt_r   <= '0;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (n_r >= root_t) begin
            n_r <= n_r - root_t;
            r_r <= (r_r >> 1) + bit_r;
          end else begin
            r_r <= r_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            comp_r  <= '0;
            state_r <= ST_NSET;
          end
        end
        ST_NSET: begin
          rem_r   <= nfull[48:17];
          nlo_r   <= nfull[16:0];
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= ST_NDIV;
        end
        ST_NDIV: begin
          rem_r <= ge ? 32'(trial - {1'b0, r_r[31:0]}) : trial[31:0];
          nlo_r <= {nlo_r[15:0], 1'b0};
          q_r   <= q_fin;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd16) begin
            case (comp_r)
              2'd0:    res_r.norm_x <= norm_v;
              2'd1:    res_r.norm_y <= norm_v;
              default: res_r.norm_z <= norm_v;
            endcase
            if (comp_r == 2'd2) begin
              state_r <= ST_EMIT;
            end else begin
              comp_r  <= comp_r + 2'd1;
              state_r <= ST_NSET;
            end
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ready_i) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_o       = out_r;

  `HGM_ASSERT(a_emit_src, $rose(out_valid_r) |-> $past(state_r == ST_EMIT), "result not from emit")
  `HGM_ASSERT(a_root_norm, (state_r == ST_NSET) |-> (r_r[31:30] != 2'b00), "root not normalized")

endmodule
